// ===== rtl/crpe_pkg.sv =====
// Shared types and constants of the Catmull-Rom point evaluator.
package crpe_pkg;

   localparam int COORD_W     = 32;
   // Horner accumulator: coefficients and partial sums stay below 24 * 2^31.
   localparam int HORNER_W    = 37;
   localparam int LANE_STAGES = 8;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic signed [HORNER_W-1:0] horner_type;

   localparam coord_type COORD_MAX = 32'sh7fff_ffff;
   localparam coord_type COORD_MIN = 32'sh8000_0000;

   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } point_type;

   // Per-stage load enables for the lane pipelines.
   typedef struct packed {
      logic [LANE_STAGES-1:0] load;
   } lane_ctl_type;

endpackage

// ===== rtl/crpe_req_if.sv =====
// Request channel: point writes and evaluate requests.
interface crpe_req_if import crpe_pkg::*; #(
   parameter int IDX_W = 6,
   parameter int T_W   = 17
) ();
   logic             valid;
   logic             ready;
   logic             func;
   logic [IDX_W-1:0] point_index;
   coord_type        coord_x;
   coord_type        coord_y;
   coord_type        coord_z;
   logic [T_W-1:0]   t_fraction;
   logic             wrap_mode;

   modport source (
      output valid, func, point_index, coord_x, coord_y, coord_z, t_fraction, wrap_mode,
      input  ready
   );

   modport sink (
      input  valid, func, point_index, coord_x, coord_y, coord_z, t_fraction, wrap_mode,
      output ready
   );
endinterface

// ===== rtl/crpe_rsp_if.sv =====
// Response channel: interpolated position and status flags.
interface crpe_rsp_if import crpe_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type pos_x;
   coord_type pos_y;
   coord_type pos_z;
   logic      index_error;
   logic      saturated;

   modport source (
      output valid, pos_x, pos_y, pos_z, index_error, saturated,
      input  ready
   );

   modport sink (
      input  valid, pos_x, pos_y, pos_z, index_error, saturated,
      output ready
   );
endinterface

// ===== rtl/crpe_point_mem.sv =====
// Control point memory: one write port, two registered read ports.
module crpe_point_mem import crpe_pkg::*; #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  point_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output point_type         rd_data_a,
   output point_type         rd_data_b
);

   point_type mem_ff [DEPTH];
   point_type rd_a_ff;
   point_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/crpe_lane.sv =====
// One coordinate lane: coefficients, three Horner steps, rounding and clipping.
module crpe_lane import crpe_pkg::*; #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic               clock,
   input  lane_ctl_type       ctl,
   input  coord_type          p0,
   input  coord_type          p1,
   input  coord_type          p2,
   input  coord_type          p3,
   input  logic [T_FRAC_BITS:0] t_frac,
   output coord_type          pos,
   output logic               clip
);

   localparam int T_W    = T_FRAC_BITS + 1;
   localparam int PROD_W = HORNER_W + T_W;

   typedef logic signed [PROD_W-1:0] prod_type;

   // floor((m + half) / 2^F)
   function automatic horner_type round_frac(input prod_type m);
      prod_type s;
      s = (m + (prod_type'(1) <<< (T_FRAC_BITS - 1))) >>> T_FRAC_BITS;
      return s[HORNER_W-1:0];
   endfunction

   function automatic prod_type mul_t(input horner_type h, input logic [T_W-1:0] t);
      logic signed [T_W:0] ts;
      ts = {1'b0, t};
      return prod_type'(h) * prod_type'(ts);
   endfunction

   horner_type e0, e1, e2, e3;

   horner_type a0_ff, a0_in, b0_ff, b0_in, c0_ff, c0_in, d0_ff, d0_in;
   logic [T_W-1:0] t0_ff, t0_in;
   prod_type       m1_ff, m1_in;
   horner_type     a1_ff, a1_in, b1_ff, b1_in, c1_ff, c1_in;
   logic [T_W-1:0] t1_ff, t1_in;
   horner_type     h1_ff, h1_in, a2_ff, a2_in, b2_ff, b2_in;
   logic [T_W-1:0] t2_ff, t2_in;
   prod_type       m2_ff, m2_in;
   horner_type     a3_ff, a3_in, b3_ff, b3_in;
   logic [T_W-1:0] t3_ff, t3_in;
   horner_type     h2_ff, h2_in, a4_ff, a4_in;
   logic [T_W-1:0] t4_ff, t4_in;
   prod_type       m3_ff, m3_in;
   horner_type     a5_ff, a5_in;
   horner_type     h3_ff, h3_in;
   horner_type     hp, half_val;
   logic [HORNER_W-COORD_W:0] hi_bits;
   coord_type      pos_ff, pos_in;
   logic           clip_ff, clip_in;

   assign e0 = horner_type'(p0);
   assign e1 = horner_type'(p1);
   assign e2 = horner_type'(p2);
   assign e3 = horner_type'(p3);

   // a = 2p1, b = p2-p0, c = 2p0-5p1+4p2-p3, d = -p0+3p1-3p2+p3
   assign a0_in = e1 <<< 1;
   assign b0_in = e2 - e0;
   assign c0_in = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
   assign d0_in = ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;
   assign t0_in = t_frac;

   assign m1_in = mul_t(d0_ff, t0_ff);
   assign a1_in = a0_ff;
   assign b1_in = b0_ff;
   assign c1_in = c0_ff;
   assign t1_in = t0_ff;

   assign h1_in = round_frac(m1_ff) + c1_ff;
   assign a2_in = a1_ff;
   assign b2_in = b1_ff;
   assign t2_in = t1_ff;

   assign m2_in = mul_t(h1_ff, t2_ff);
   assign a3_in = a2_ff;
   assign b3_in = b2_ff;
   assign t3_in = t2_ff;

   assign h2_in = round_frac(m2_ff) + b3_ff;
   assign a4_in = a3_ff;
   assign t4_in = t3_ff;

   assign m3_in = mul_t(h2_ff, t4_ff);
   assign a5_in = a4_ff;

   assign h3_in = round_frac(m3_ff) + a5_ff;

   // floor((h + 1) / 2), then clip to 32 bits
   assign hp       = h3_ff + horner_type'(1);
   assign half_val = hp >>> 1;
   assign hi_bits  = half_val[HORNER_W-1:COORD_W-1];
   assign clip_in  = !((&hi_bits) || (~|hi_bits));
   assign pos_in   = clip_in ? (half_val[HORNER_W-1] ? COORD_MIN : COORD_MAX)
                             : half_val[COORD_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         a0_ff <= a0_in;
         b0_ff <= b0_in;
         c0_ff <= c0_in;
         d0_ff <= d0_in;
         t0_ff <= t0_in;
      end
      if (ctl.load[1]) begin
         m1_ff <= m1_in;
         a1_ff <= a1_in;
         b1_ff <= b1_in;
         c1_ff <= c1_in;
         t1_ff <= t1_in;
      end
      if (ctl.load[2]) begin
         h1_ff <= h1_in;
         a2_ff <= a2_in;
         b2_ff <= b2_in;
         t2_ff <= t2_in;
      end
      if (ctl.load[3]) begin
         m2_ff <= m2_in;
         a3_ff <= a3_in;
         b3_ff <= b3_in;
         t3_ff <= t3_in;
      end
      if (ctl.load[4]) begin
         h2_ff <= h2_in;
         a4_ff <= a4_in;
         t4_ff <= t4_in;
      end
      if (ctl.load[5]) begin
         m3_ff <= m3_in;
         a5_ff <= a5_in;
      end
      if (ctl.load[6]) begin
         h3_ff <= h3_in;
      end
      if (ctl.load[7]) begin
         pos_ff  <= pos_in;
         clip_ff <= clip_in;
      end
   end

   assign pos  = pos_ff;
   assign clip = clip_ff;

endmodule

// ===== rtl/catmull_rom_point_eval.sv =====
// Top level: index rules, point memories, three coordinate lanes and result merge.
//
//   channel  direction  handshake         contents
//   req_ch   in         valid/ready       func, point_index, coord_x/y/z, t_fraction, wrap_mode
//   rsp_ch   out        valid/ready       pos_x/y/z, index_error, saturated
//   csr      in         csr_we            points_in_use
//
// One request per cycle sustained while rsp_ch.ready stays high; a write gives no response.
// An evaluate passes the memory read register, eight lane stages
// (three multiply/round pairs) and the merge register.
// Reset clears the pipeline valids and sets points_in_use to 4; table contents stay.
// Stalls collapse bubbles: req_ch.ready drops only when every stage is full
// and the response register is held.
module catmull_rom_point_eval import crpe_pkg::*; #(
   parameter int MAX_POINTS  = 64,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   crpe_req_if.sink                         req_ch,
   crpe_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [$clog2(MAX_POINTS+1)-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int T_W   = T_FRAC_BITS + 1;
   localparam int NSTG  = LANE_STAGES + 1;

   logic [CNT_W-1:0] points_ff, points_in;
   logic [CNT_W-1:0] n_lim, n_m3, idx_c;
   logic [IDX_W-1:0] idx_a, a_dir;
   logic [IDX_W-1:0] rd_addr0, rd_addr1, rd_addr2, rd_addr3;
   logic             is_err, is_zero, beyond, is_direct, is_curve;
   logic [T_W-1:0]   t_one, t_clamp, t_ff, t_in;
   logic             eval_req, wr_en;
   point_type        wr_point;
   point_type        pt0, pt1, pt2, pt3;

   logic [NSTG-1:0]  v_ff, v_in, err_ff, err_in, ld;
   logic             ld_out;
   lane_ctl_type     lane_ctl;

   coord_type        lane_x, lane_y, lane_z;
   logic             clip_x, clip_y, clip_z;

   logic             out_v_ff, out_v_in;
   coord_type        pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic             ierr_ff, ierr_in, sat_ff, sat_in;

   // ---- index rules ----
   assign n_lim = (points_ff < CNT_W'(4))          ? CNT_W'(4) :
                  (points_ff > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : points_ff;
   assign n_m3      = n_lim - CNT_W'(3);
   assign idx_c     = CNT_W'(req_ch.point_index);
   assign idx_a     = idx_c[IDX_W-1:0];
   assign is_err    = idx_c >= n_lim;
   assign is_zero   = idx_c == '0;
   assign beyond    = idx_c > n_m3;
   assign is_direct = !is_err && (is_zero || (beyond && !req_ch.wrap_mode));
   assign is_curve  = !is_err && !is_direct;

   // direct returns travel through the lanes as p1 with t = 0
   assign a_dir    = is_zero ? IDX_W'(1) : n_m3[IDX_W-1:0];
   assign rd_addr0 = is_curve ? idx_a - IDX_W'(1) : a_dir;
   assign rd_addr1 = is_curve ? idx_a : a_dir;
   assign rd_addr2 = !is_curve ? a_dir : (beyond ? IDX_W'(1) : idx_a + IDX_W'(1));
   assign rd_addr3 = !is_curve ? a_dir : (beyond ? IDX_W'(2) : idx_a + IDX_W'(2));

   assign t_one   = T_W'(1) << T_FRAC_BITS;
   assign t_clamp = (req_ch.t_fraction > t_one) ? t_one : req_ch.t_fraction;
   assign t_in    = is_curve ? t_clamp : '0;

   assign eval_req = req_ch.valid && (req_ch.func == FUNC_EVAL);
   assign wr_en    = req_ch.valid && ld[0] && (req_ch.func == FUNC_WRITE)
                     && (idx_c < CNT_W'(MAX_POINTS));
   assign wr_point = '{x: req_ch.coord_x, y: req_ch.coord_y, z: req_ch.coord_z};

   assign points_in = csr_we ? csr_wdata : points_ff;

   // ---- stage control: a stage loads when empty or when the next one moves ----
   assign ld_out = !out_v_ff || rsp_ch.ready;

   always_comb begin
      logic nxt;
      nxt = ld_out;
      for (int k = NSTG - 1; k >= 0; k--) begin
         ld[k] = !v_ff[k] || nxt;
         nxt   = ld[k];
      end
   end

   always_comb begin
      v_in[0]   = ld[0] ? eval_req : v_ff[0];
      err_in[0] = ld[0] ? is_err : err_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         v_in[k]   = ld[k] ? v_ff[k-1] : v_ff[k];
         err_in[k] = ld[k] ? err_ff[k-1] : err_ff[k];
      end
   end

   assign lane_ctl.load = ld[NSTG-1:1];
   assign req_ch.ready  = ld[0];

   // ---- memories: two copies give four reads a cycle ----
   crpe_point_mem #(
      .DEPTH  (MAX_POINTS),
      .ADDR_W (IDX_W)
   ) u_mem_lo (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (idx_a),
      .wr_data   (wr_point),
      .rd_en     (ld[0]),
      .rd_addr_a (rd_addr0),
      .rd_addr_b (rd_addr1),
      .rd_data_a (pt0),
      .rd_data_b (pt1)
   );

   crpe_point_mem #(
      .DEPTH  (MAX_POINTS),
      .ADDR_W (IDX_W)
   ) u_mem_hi (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (idx_a),
      .wr_data   (wr_point),
      .rd_en     (ld[0]),
      .rd_addr_a (rd_addr2),
      .rd_addr_b (rd_addr3),
      .rd_data_a (pt2),
      .rd_data_b (pt3)
   );

   // ---- lanes ----
   crpe_lane #(.T_FRAC_BITS(T_FRAC_BITS)) u_lane_x (
      .clock (clock), .ctl (lane_ctl),
      .p0 (pt0.x), .p1 (pt1.x), .p2 (pt2.x), .p3 (pt3.x),
      .t_frac (t_ff), .pos (lane_x), .clip (clip_x)
   );

   crpe_lane #(.T_FRAC_BITS(T_FRAC_BITS)) u_lane_y (
      .clock (clock), .ctl (lane_ctl),
      .p0 (pt0.y), .p1 (pt1.y), .p2 (pt2.y), .p3 (pt3.y),
      .t_frac (t_ff), .pos (lane_y), .clip (clip_y)
   );

   crpe_lane #(.T_FRAC_BITS(T_FRAC_BITS)) u_lane_z (
      .clock (clock), .ctl (lane_ctl),
      .p0 (pt0.z), .p1 (pt1.z), .p2 (pt2.z), .p3 (pt3.z),
      .t_frac (t_ff), .pos (lane_z), .clip (clip_z)
   );

   // ---- merge ----
   assign out_v_in = ld_out ? v_ff[NSTG-1] : out_v_ff;
   assign ierr_in  = err_ff[NSTG-1];
   assign pos_x_in = ierr_in ? '0 : lane_x;
   assign pos_y_in = ierr_in ? '0 : lane_y;
   assign pos_z_in = ierr_in ? '0 : lane_z;
   assign sat_in   = !ierr_in && (clip_x || clip_y || clip_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         out_v_ff  <= 1'b0;
         points_ff <= CNT_W'(4);
      end else begin
         v_ff      <= v_in;
         out_v_ff  <= out_v_in;
         points_ff <= points_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff <= err_in;
      if (ld[0]) begin
         t_ff <= t_in;
      end
      if (ld_out) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         ierr_ff  <= ierr_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.pos_x       = pos_x_ff;
   assign rsp_ch.pos_y       = pos_y_ff;
   assign rsp_ch.pos_z       = pos_z_ff;
   assign rsp_ch.index_error = ierr_ff;
   assign rsp_ch.saturated   = sat_ff;

`ifndef SYNTH
   a_reset_clears : assert property (@(posedge clock)
      reset |=> (v_ff == '0) && !out_v_ff)
      else $error("pipeline not empty after reset");

   a_eval_enters : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.func == FUNC_EVAL) |=> v_ff[0])
      else $error("accepted evaluate request lost at entry");

   a_write_no_item : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.func == FUNC_WRITE) |=> !v_ff[0])
      else $error("write request produced a pipeline item");

   a_full_stalls : assert property (@(posedge clock) disable iff (reset)
      ((&v_ff) && out_v_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken while pipeline full and stalled");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.index_error) |->
         (rsp_ch.pos_x == '0) && (rsp_ch.pos_y == '0) && (rsp_ch.pos_z == '0)
         && !rsp_ch.saturated)
      else $error("index error response carries data");
`endif

endmodule

// ===== verif/catmull_rom_point_eval_tb.sv =====
// Self-checking testbench for catmull_rom_point_eval: table-driven directed requests, then random phases.
module catmull_rom_point_eval_tb import crpe_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_POINTS   = 64;
   localparam int          T_FRAC       = 16;
   localparam longint      T_ONE        = 64'sd65536;
   localparam longint      T_HALF       = 64'sd32768;
   localparam int          PHASES       = 8;
   localparam int          PHASE_ITEMS  = 216;
   localparam int          HOLD_PHASE   = 4;
   localparam int          PAUSE_PHASE  = 5;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          DRAIN_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   // points_in_use per phase, phase 0 in the low bits; 0, 3, 65 and 127 get clamped
   localparam logic [PHASES-1:0][6:0] PHASE_COUNTS =
      {7'd4, 7'd65, 7'd3, 7'd37, 7'd5, 7'd127, 7'd0, 7'd64};

   typedef struct packed {
      logic        func;
      logic [5:0]  point_index;
      coord_type   coord_x;
      coord_type   coord_y;
      coord_type   coord_z;
      logic [16:0] t_fraction;
      logic        wrap_mode;
   } request_type;

   typedef struct packed {
      coord_type pos_x;
      coord_type pos_y;
      coord_type pos_z;
      logic      index_error;
      logic      saturated;
   } position_type;

   typedef struct packed {
      request_type  req;
      logic         typed;
      position_type want;
   } stim_row_type;

   localparam point_type PT_A = '{z: 32'sh0000_0000, y: COORD_MAX, x: COORD_MIN};
   localparam point_type PT_B = '{z: 32'shffff_ffff, y: COORD_MIN, x: COORD_MAX};
   localparam point_type PT_C = '{z: COORD_MAX, y: 32'shfffe_8000, x: 32'sh0001_0000};
   localparam point_type PT_D = '{z: COORD_MIN, y: COORD_MAX, x: COORD_MIN};
   localparam point_type PT_E = '{z: 32'shffff_ffff, y: 32'shffff_ffff, x: 32'shffff_ffff};
   localparam point_type PT_F = '{z: 32'sh0001_0000, y: 32'shffff_ffff, x: 32'sh0000_0001};
   localparam position_type INDEX_ERROR_POS =
      '{pos_x: '0, pos_y: '0, pos_z: '0, index_error: 1'b1, saturated: 1'b0};

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [6:0]  csr_wdata;
   logic        rsp_hold = 1'b0;
   int          sender_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          phase_num = -1;
   int          mismatch_count = 0;
   int unsigned cycle_count = 0;

   // predictor state
   point_type    point_mem [MAX_POINTS];
   logic         point_loaded [MAX_POINTS];
   logic [6:0]   count_reg = 7'd4;
   position_type expected_positions [$];
   stim_row_type directed [$];

   crpe_req_if req_ch ();
   crpe_rsp_if rsp_ch ();

   catmull_rom_point_eval u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int active_count();
      if (count_reg < 7'd4) return 4;
      if (count_reg > 7'(MAX_POINTS)) return MAX_POINTS;
      return int'(count_reg);
   endfunction

   function automatic coord_type curve_coord(input coord_type p0, input coord_type p1,
                                             input coord_type p2, input coord_type p3,
                                             input longint t, inout bit clipped);
      longint a, b, c, d, h, pos;
      a = 2 * longint'(p1);
      b = longint'(p2) - longint'(p0);
      c = 2 * longint'(p0) - 5 * longint'(p1) + 4 * longint'(p2) - longint'(p3);
      d = -longint'(p0) + 3 * longint'(p1) - 3 * longint'(p2) + longint'(p3);
      h = d;
      h = ((h * t + T_HALF) >>> T_FRAC) + c;
      h = ((h * t + T_HALF) >>> T_FRAC) + b;
      h = ((h * t + T_HALF) >>> T_FRAC) + a;
      pos = (h + 1) >>> 1;
      if (pos > longint'(COORD_MAX)) begin
         pos = longint'(COORD_MAX);
         clipped = 1'b1;
      end else if (pos < longint'(COORD_MIN)) begin
         pos = longint'(COORD_MIN);
         clipped = 1'b1;
      end
      return pos[31:0];
   endfunction

   function automatic position_type point_pos(input point_type p);
      return '{pos_x: p.x, pos_y: p.y, pos_z: p.z, index_error: 1'b0, saturated: 1'b0};
   endfunction

   // Updates the point table on writes; returns 1 when the request yields a result.
   function automatic logic eval_catmull_rom(input request_type r, output position_type pos);
      int     n, i, i2, i3;
      longint t;
      bit     clipped;
      pos = '0;
      clipped = 1'b0;
      if (r.func == FUNC_WRITE) begin
         point_mem[r.point_index] = '{z: r.coord_z, y: r.coord_y, x: r.coord_x};
         point_loaded[r.point_index] = 1'b1;
         return 1'b0;
      end
      n = active_count();
      i = int'(r.point_index);
      if (i >= n) begin
         pos.index_error = 1'b1;
         return 1'b1;
      end
      if (i == 0) begin
         pos = point_pos(point_mem[1]);
         return 1'b1;
      end
      if (i > n - 3) begin
         if (!r.wrap_mode) begin
            pos = point_pos(point_mem[n - 3]);
            return 1'b1;
         end
         i2 = 1;
         i3 = 2;
      end else begin
         i2 = i + 1;
         i3 = i + 2;
      end
      t = (r.t_fraction > 17'd65536) ? T_ONE : longint'(r.t_fraction);
      pos.pos_x = curve_coord(point_mem[i - 1].x, point_mem[i].x, point_mem[i2].x,
                              point_mem[i3].x, t, clipped);
      pos.pos_y = curve_coord(point_mem[i - 1].y, point_mem[i].y, point_mem[i2].y,
                              point_mem[i3].y, t, clipped);
      pos.pos_z = curve_coord(point_mem[i - 1].z, point_mem[i].z, point_mem[i2].z,
                              point_mem[i3].z, t, clipped);
      pos.saturated = clipped;
      return 1'b1;
   endfunction

   // First table entry an evaluate request would read before it was loaded, or -1.
   function automatic int missing_entry(input int i, input logic wrap);
      int n;
      int need [4];
      n = active_count();
      if (i >= n) return -1;
      if (i == 0) need = '{1, 1, 1, 1};
      else if (i > n - 3 && !wrap) need = '{n - 3, n - 3, n - 3, n - 3};
      else if (i > n - 3) need = '{i - 1, i, 1, 2};
      else need = '{i - 1, i, i + 1, i + 2};
      foreach (need[k]) begin
         if (!point_loaded[need[k]]) return need[k];
      end
      return -1;
   endfunction

   function automatic coord_type random_coord();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(3, 0))
         0: return v;
         1, 2: return {{8{v[23]}}, v[23:0]};
         default: begin
            case (v[1:0])
               2'd0: return COORD_MAX;
               2'd1: return COORD_MIN;
               2'd2: return 32'sh0;
               default: return 32'shffff_ffff;
            endcase
         end
      endcase
   endfunction

   function automatic logic [16:0] random_t();
      case ($urandom_range(7, 0))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(131071, 65537));
         default: return 17'($urandom_range(65535, 0));
      endcase
   endfunction

   function automatic request_type write_req(input int idx, input point_type p);
      return '{func: FUNC_WRITE, point_index: 6'(idx), coord_x: p.x, coord_y: p.y,
               coord_z: p.z, t_fraction: random_t(), wrap_mode: 1'($urandom)};
   endfunction

   function automatic request_type eval_req(input int idx, input logic [16:0] t,
                                            input logic wrap);
      return '{func: FUNC_EVAL, point_index: 6'(idx), coord_x: $urandom, coord_y: $urandom,
               coord_z: $urandom, t_fraction: t, wrap_mode: wrap};
   endfunction

   function automatic request_type random_request();
      request_type r;
      int          n, i, miss;
      n = active_count();
      r.func        = ($urandom_range(99, 0) < 30) ? FUNC_WRITE : FUNC_EVAL;
      r.coord_x     = random_coord();
      r.coord_y     = random_coord();
      r.coord_z     = random_coord();
      r.t_fraction  = random_t();
      r.wrap_mode   = 1'($urandom);
      if (r.func == FUNC_WRITE) begin
         r.point_index = ($urandom_range(3, 0) == 0) ? 6'($urandom)
                                                     : 6'($urandom_range(n - 1, 0));
         return r;
      end
      case ($urandom_range(9, 0))
         0: i = 0;
         1: i = n - 1;
         2, 3: i = n - 3 + int'($urandom_range(2, 0));
         4: i = (n == MAX_POINTS) ? int'($urandom_range(63, 0)) : int'($urandom_range(63, n));
         default: i = int'($urandom_range(n - 1, 1));
      endcase
      r.point_index = 6'(i);
      // an evaluate that would touch an unloaded entry becomes a load of that entry
      miss = missing_entry(i, r.wrap_mode);
      if (miss >= 0) begin
         r.func        = FUNC_WRITE;
         r.point_index = 6'(miss);
      end
      return r;
   endfunction

   task automatic send_request(input request_type r, input logic typed,
                               input position_type want);
      position_type predicted;
      @(negedge clock);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= r.func;
      req_ch.point_index <= r.point_index;
      req_ch.coord_x     <= r.coord_x;
      req_ch.coord_y     <= r.coord_y;
      req_ch.coord_z     <= r.coord_z;
      req_ch.t_fraction  <= r.t_fraction;
      req_ch.wrap_mode   <= r.wrap_mode;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (eval_catmull_rom(r, predicted))
         expected_positions.push_back(typed ? want : predicted);
   endtask

   // Hold off requests until all results are back and the pipeline has gone quiet.
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_positions.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_points_in_use(input logic [6:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      count_reg = value;
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      position_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_positions.size() == 0) begin
            $error("result with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_positions.pop_front();
            check_field("pos_x", want.pos_x, rsp_ch.pos_x);
            check_field("pos_y", want.pos_y, rsp_ch.pos_y);
            check_field("pos_z", want.pos_z, rsp_ch.pos_z);
            check_field("index_error", 32'(want.index_error), 32'(rsp_ch.index_error));
            check_field("saturated", 32'(want.saturated), 32'(rsp_ch.saturated));
         end
      end
   end

   always @(negedge clock) begin
      if (reset || rsp_hold) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
   end

   // long receiver hold-off so the pipeline fills and backpressures the request side
   initial begin
      wait (phase_num == HOLD_PHASE);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("catmull_rom_point_eval: mismatch");
         $finish;
      end
   end

   initial begin
      request_type r;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_WRITE;
      req_ch.point_index = '0;
      req_ch.coord_x     = '0;
      req_ch.coord_y     = '0;
      req_ch.coord_z     = '0;
      req_ch.t_fraction  = '0;
      req_ch.wrap_mode   = 1'b0;
      foreach (point_loaded[k]) point_loaded[k] = 1'b0;

      // points_in_use is 4 out of reset
      directed.push_back('{req: write_req(0, PT_A), typed: 1'b0, want: '0});
      directed.push_back('{req: write_req(1, PT_B), typed: 1'b0, want: '0});
      directed.push_back('{req: write_req(2, PT_C), typed: 1'b0, want: '0});
      directed.push_back('{req: write_req(3, PT_D), typed: 1'b0, want: '0});
      directed.push_back('{req: eval_req(0, 17'd0, 1'b0), typed: 1'b1, want: point_pos(PT_B)});
      directed.push_back('{req: eval_req(0, 17'd131071, 1'b1), typed: 1'b1,
                           want: point_pos(PT_B)});
      // t = 0 lands on p1, t = one (or clamped above one) lands on p2
      directed.push_back('{req: eval_req(1, 17'd0, 1'b0), typed: 1'b1, want: point_pos(PT_B)});
      directed.push_back('{req: eval_req(1, 17'd65536, 1'b0), typed: 1'b1,
                           want: point_pos(PT_C)});
      directed.push_back('{req: eval_req(1, 17'd131071, 1'b1), typed: 1'b1,
                           want: point_pos(PT_C)});
      directed.push_back('{req: eval_req(1, 17'd65537, 1'b0), typed: 1'b1,
                           want: point_pos(PT_C)});
      directed.push_back('{req: eval_req(1, 17'd32768, 1'b0), typed: 1'b0, want: '0});
      directed.push_back('{req: eval_req(1, 17'd1, 1'b1), typed: 1'b0, want: '0});
      // clamped end returns point n-3
      directed.push_back('{req: eval_req(2, 17'd32768, 1'b0), typed: 1'b1,
                           want: point_pos(PT_B)});
      directed.push_back('{req: eval_req(3, 17'd65535, 1'b0), typed: 1'b1,
                           want: point_pos(PT_B)});
      directed.push_back('{req: eval_req(2, 17'd49152, 1'b1), typed: 1'b0, want: '0});
      directed.push_back('{req: eval_req(3, 17'd16384, 1'b1), typed: 1'b0, want: '0});
      directed.push_back('{req: eval_req(4, 17'd32768, 1'b0), typed: 1'b1,
                           want: INDEX_ERROR_POS});
      directed.push_back('{req: eval_req(63, 17'd131071, 1'b1), typed: 1'b1,
                           want: INDEX_ERROR_POS});
      directed.push_back('{req: write_req(63, PT_E), typed: 1'b0, want: '0});
      directed.push_back('{req: write_req(1, PT_F), typed: 1'b0, want: '0});
      directed.push_back('{req: eval_req(1, 17'd65535, 1'b0), typed: 1'b0, want: '0});
      directed.push_back('{req: eval_req(2, 17'd40000, 1'b1), typed: 1'b0, want: '0});
      directed.push_back('{req: eval_req(1, 17'd0, 1'b1), typed: 1'b1, want: point_pos(PT_F)});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[k]) send_request(directed[k].req, directed[k].typed, directed[k].want);

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         set_points_in_use(PHASE_COUNTS[ph]);
         case (ph % 4)
            0: begin sender_idle_pct <= 0;  rsp_stall_pct <= 0;  end
            1: begin sender_idle_pct <= 53; rsp_stall_pct <= 0;  end
            2: begin sender_idle_pct <= 0;  rsp_stall_pct <= 53; end
            default: begin sender_idle_pct <= 23; rsp_stall_pct <= 23; end
         endcase
         phase_num = ph;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == PAUSE_PHASE && k == PHASE_ITEMS / 2) settle();
            r = random_request();
            send_request(r, 1'b0, '0);
         end
      end
      settle();

      if (mismatch_count == 0) $display("catmull_rom_point_eval: match");
      else $display("catmull_rom_point_eval: mismatch");
      $finish;
   end

endmodule
